// ----- rtl/brf_pkg.sv -----
`default_nettype none

package brf_pkg;

    // Store geometry; DEPTH must be a power of two
    localparam int DEPTH     = 1024;
    localparam int PTR_W     = $clog2(DEPTH);
    localparam int MAX_BURST = 64;
    localparam int BURST_W   = $clog2(MAX_BURST + 1);

    // Fixed field widths of the channels
    localparam int CMD_W     = 3;
    localparam int BYTE_W    = 8;
    localparam int FIELD_W   = 10;

    // Width wide enough to compare a requested count with a space figure
    localparam int MIN_W     = (PTR_W > FIELD_W) ? PTR_W : FIELD_W;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE   = CMD_W'(0),
        CMD_READ    = CMD_W'(1),
        CMD_DISCARD = CMD_W'(2),
        CMD_CLEAR   = CMD_W'(3),
        CMD_QUERY   = CMD_W'(4)
    } brf_cmd_t;

    typedef enum logic {
        ST_IDLE,
        ST_BURST
    } brf_state_t;

    // Occupancy figures derived from the two pointers
    typedef struct packed {
        logic [PTR_W-1:0]   rd_space;
        logic [PTR_W-1:0]   wr_space;
        logic [FIELD_W-1:0] read_space;
        logic [FIELD_W-1:0] write_space;
        logic [FIELD_W-1:0] read_seg_first;
        logic [FIELD_W-1:0] read_seg_second;
        logic [FIELD_W-1:0] write_seg_first;
        logic [FIELD_W-1:0] write_seg_second;
    } brf_status_t;

endpackage

`default_nettype wire

// ----- rtl/brf_if.sv -----
`default_nettype none

interface brf_req_if;
    logic                         valid;
    logic                         ready;
    logic [brf_pkg::CMD_W-1:0]    command;
    logic [brf_pkg::BYTE_W-1:0]   data_in;
    logic [brf_pkg::FIELD_W-1:0]  count;

    modport source (output valid, output command, output data_in, output count,
                    input ready);
    modport sink   (input valid, input command, input data_in, input count,
                    output ready);
endinterface

interface brf_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [brf_pkg::BYTE_W-1:0]   data_out;
    logic                         data_valid;
    logic                         last;
    logic [brf_pkg::FIELD_W-1:0]  done_count;
    logic [brf_pkg::FIELD_W-1:0]  read_space;
    logic [brf_pkg::FIELD_W-1:0]  write_space;
    logic [brf_pkg::FIELD_W-1:0]  read_seg_first;
    logic [brf_pkg::FIELD_W-1:0]  read_seg_second;
    logic [brf_pkg::FIELD_W-1:0]  write_seg_first;
    logic [brf_pkg::FIELD_W-1:0]  write_seg_second;

    modport source (output valid, output data_out, output data_valid, output last,
                    output done_count, output read_space, output write_space,
                    output read_seg_first, output read_seg_second,
                    output write_seg_first, output write_seg_second,
                    input ready);
    modport sink   (input valid, input data_out, input data_valid, input last,
                    input done_count, input read_space, input write_space,
                    input read_seg_first, input read_seg_second,
                    input write_seg_first, input write_seg_second,
                    output ready);
endinterface

`default_nettype wire

// ----- rtl/brf_ram.sv -----
`default_nettype none

module brf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/brf_status.sv -----
`default_nettype none

module brf_status (
    input  wire logic [brf_pkg::PTR_W-1:0] rd_ptr,
    input  wire logic [brf_pkg::PTR_W-1:0] wr_ptr,
    output brf_pkg::brf_status_t           status
);

    import brf_pkg::*;

    logic [PTR_W-1:0] rs;
    logic [PTR_W-1:0] ws;
    logic [PTR_W:0]   rd_end;
    logic [PTR_W:0]   wr_end;
    logic [PTR_W:0]   rd_first_wrap;
    logic [PTR_W:0]   wr_first_wrap;

    // Modulo arithmetic on the pointers; one slot always stays empty
    assign rs = wr_ptr - rd_ptr;
    assign ws = rd_ptr - wr_ptr - PTR_W'(1);

    assign rd_end        = {1'b0, rd_ptr} + {1'b0, rs};
    assign wr_end        = {1'b0, wr_ptr} + {1'b0, ws};
    assign rd_first_wrap = (PTR_W+1)'(DEPTH) - {1'b0, rd_ptr};
    assign wr_first_wrap = (PTR_W+1)'(DEPTH) - {1'b0, wr_ptr};

    always_comb
    begin
        status.rd_space    = rs;
        status.wr_space    = ws;
        status.read_space  = FIELD_W'(rs);
        status.write_space = FIELD_W'(ws);

        // Split each region at the end of the store
        if (rd_end > (PTR_W+1)'(DEPTH))
        begin
            status.read_seg_first  = FIELD_W'(rd_first_wrap);
            status.read_seg_second = FIELD_W'(rd_end[PTR_W-1:0]);
        end
        else
        begin
            status.read_seg_first  = FIELD_W'(rs);
            status.read_seg_second = '0;
        end

        if (wr_end > (PTR_W+1)'(DEPTH))
        begin
            status.write_seg_first  = FIELD_W'(wr_first_wrap);
            status.write_seg_second = FIELD_W'(wr_end[PTR_W-1:0]);
        end
        else
        begin
            status.write_seg_first  = FIELD_W'(ws);
            status.write_seg_second = '0;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/byte_ring_fifo.sv -----
`default_nettype none

// Byte FIFO over a power-of-two ring store (brf_pkg::DEPTH bytes, at most DEPTH-1
// held, one slot always kept empty). Each request transfer carries one command:
// write a byte (dropped with done_count 0 when full), read a burst of
// min(count, read_space, MAX_BURST) bytes, discard up to count bytes, clear both
// pointers, or query; codes 5 to 7 act as query. A read burst answers with one
// response transfer per byte, the final one marked last, and every response of
// the burst reports the state after the whole burst; a read with nothing
// available, and every other command, answers with a single response carrying
// data_valid 0 and last 1. A non-read command's response is valid in the cycle
// after its request transfer; a read burst fetches its bytes in turn through the
// single registered read port of the byte store, the next fetch overlapping the
// move of the last byte into the response register. One command is in work at
// a time: request.ready falls during a burst and while a response waits to be
// taken. Reset clears pointers and control state; the store needs no clearing.
module byte_ring_fifo (
    input  wire logic clk,
    input  wire logic rst_n,
    brf_req_if.sink   request,
    brf_rsp_if.source response
);

    import brf_pkg::*;

    brf_state_t           state_reg, state_next;
    logic [PTR_W-1:0]     rp_reg, rp_next;
    logic [PTR_W-1:0]     wp_reg, wp_next;
    logic [PTR_W-1:0]     rd_addr_reg, rd_addr_next;
    logic [BURST_W-1:0]   issue_left_reg, issue_left_next;
    logic [BURST_W-1:0]   out_left_reg, out_left_next;
    logic                 pend_reg, pend_next;
    logic [FIELD_W-1:0]   burst_n_reg, burst_n_next;

    logic                 out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]    out_data_reg, out_data_next;
    logic                 out_dvalid_reg, out_dvalid_next;
    logic                 out_last_reg, out_last_next;
    logic [FIELD_W-1:0]   out_done_reg, out_done_next;

    brf_status_t          status;
    logic                 out_free;
    logic                 accept;
    logic                 issue;
    logic                 load_byte;
    logic                 ram_we;
    logic [BYTE_W-1:0]    ram_rdata;

    logic [MIN_W-1:0]     count_w;
    logic [MIN_W-1:0]     avail_w;
    logic [MIN_W-1:0]     clamp_w;
    logic [BURST_W-1:0]   burst_len;

    brf_status u_status (
        .rd_ptr (rp_reg),
        .wr_ptr (wp_reg),
        .status (status)
    );

    brf_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wp_reg),
        .wdata (request.data_in),
        .re    (issue),
        .raddr (rd_addr_reg),
        .rdata (ram_rdata)
    );

    // The response register is free when empty or when its transfer happens now
    assign out_free      = !out_valid_reg || response.ready;
    assign request.ready = (state_reg == ST_IDLE) && out_free;
    assign accept        = request.valid && request.ready;

    // A fetched byte sits on the store output until it moves into the
    // response register; hold further reads until then
    assign load_byte = pend_reg && out_free;
    assign issue     = (state_reg == ST_BURST) && (issue_left_reg != '0)
                       && (!pend_reg || out_free);

    assign ram_we = accept && (brf_cmd_t'(request.command) == CMD_WRITE)
                    && (status.wr_space != '0);

    // Clamp the requested count to the readable amount, then to the burst limit
    assign count_w = MIN_W'(request.count);
    assign avail_w = MIN_W'(status.rd_space);
    assign clamp_w = (count_w > avail_w) ? avail_w : count_w;
    assign burst_len = (clamp_w > MIN_W'(MAX_BURST)) ? BURST_W'(MAX_BURST)
                                                      : BURST_W'(clamp_w);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            rp_reg         <= '0;
            wp_reg         <= '0;
            issue_left_reg <= '0;
            out_left_reg   <= '0;
            pend_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            rp_reg         <= rp_next;
            wp_reg         <= wp_next;
            issue_left_reg <= issue_left_next;
            out_left_reg   <= out_left_next;
            pend_reg       <= pend_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_addr_reg    <= rd_addr_next;
        burst_n_reg    <= burst_n_next;
        out_data_reg   <= out_data_next;
        out_dvalid_reg <= out_dvalid_next;
        out_last_reg   <= out_last_next;
        out_done_reg   <= out_done_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        rp_next         = rp_reg;
        wp_next         = wp_reg;
        rd_addr_next    = rd_addr_reg;
        issue_left_next = issue_left_reg;
        out_left_next   = out_left_reg;
        pend_next       = pend_reg;
        burst_n_next    = burst_n_reg;
        out_valid_next  = out_valid_reg && !response.ready;
        out_data_next   = out_data_reg;
        out_dvalid_next = out_dvalid_reg;
        out_last_next   = out_last_reg;
        out_done_next   = out_done_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    // Single-response default; the read burst overrides it
                    out_valid_next  = 1'b1;
                    out_data_next   = '0;
                    out_dvalid_next = 1'b0;
                    out_last_next   = 1'b1;
                    out_done_next   = '0;

                    case (brf_cmd_t'(request.command))
                        CMD_WRITE:
                        begin
                            if (status.wr_space != '0)
                            begin
                                wp_next       = wp_reg + PTR_W'(1);
                                out_done_next = FIELD_W'(1);
                            end
                        end
                        CMD_READ:
                        begin
                            if (burst_len != '0)
                            begin
                                // Advance the read pointer now: every byte of
                                // the burst reports the final state
                                out_valid_next  = 1'b0;
                                rp_next         = rp_reg + PTR_W'(burst_len);
                                rd_addr_next    = rp_reg;
                                issue_left_next = burst_len;
                                out_left_next   = burst_len;
                                burst_n_next    = FIELD_W'(burst_len);
                                state_next      = ST_BURST;
                            end
                        end
                        CMD_DISCARD:
                        begin
                            rp_next       = rp_reg + PTR_W'(clamp_w);
                            out_done_next = FIELD_W'(clamp_w);
                        end
                        CMD_CLEAR:
                        begin
                            rp_next = '0;
                            wp_next = '0;
                        end
                        default:
                        begin
                            // Query and unused codes change nothing
                        end
                    endcase
                end
            end
            ST_BURST:
            begin
                if (issue)
                begin
                    rd_addr_next    = rd_addr_reg + PTR_W'(1);
                    issue_left_next = issue_left_reg - BURST_W'(1);
                end
                if (issue)
                begin
                    pend_next = 1'b1;
                end
                else if (load_byte)
                begin
                    pend_next = 1'b0;
                end

                if (load_byte)
                begin
                    out_valid_next  = 1'b1;
                    out_data_next   = ram_rdata;
                    out_dvalid_next = 1'b1;
                    out_last_next   = (out_left_reg == BURST_W'(1));
                    out_done_next   = burst_n_reg;
                    out_left_next   = out_left_reg - BURST_W'(1);
                    if (out_left_reg == BURST_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Occupancy fields follow the pointers, which hold while a response waits
    assign response.valid            = out_valid_reg;
    assign response.data_out         = out_data_reg;
    assign response.data_valid       = out_dvalid_reg;
    assign response.last             = out_last_reg;
    assign response.done_count       = out_done_reg;
    assign response.read_space       = status.read_space;
    assign response.write_space      = status.write_space;
    assign response.read_seg_first   = status.read_seg_first;
    assign response.read_seg_second  = status.read_seg_second;
    assign response.write_seg_first  = status.write_seg_first;
    assign response.write_seg_second = status.write_seg_second;

endmodule

`default_nettype wire
